// ===== hw/rtl/timestamp_min_heap_queue_unit_defines.svh =====
// Assertion macros used by the heap queue controller.
`ifndef TIMESTAMP_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH
`define TIMESTAMP_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define TMHQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmhq assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define TMHQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmhq assertion failed");

`endif

// ===== hw/rtl/tmhq_pkg.sv =====
package tmhq_pkg;

  localparam int TIME_W  = 32;
  localparam int TAG_W   = 45;
  localparam int FILL_W  = 7;

  typedef struct packed {
    logic        op;
    logic [31:0] due_time;
    logic [9:0]  slot_hint;
    logic [15:0] owner_id;
    logic [2:0]  word_count;
    logic [15:0] payload_ref;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_time;
    logic [9:0]  out_slot;
    logic [15:0] out_owner;
    logic [2:0]  out_words;
    logic [15:0] out_payload;
    logic [6:0]  fill_level;
  } out_word_t;

  localparam logic       OP_PUSH = 1'b0;
  localparam logic       OP_POP  = 1'b1;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POP_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP
  } state_t;

  // Controller -> datapath commands
  typedef enum logic [1:0] {
    MUX_NONE,
    MUX_ENT,
    MUX_UP,
    MUX_DN
  } wmux_t;

  typedef struct packed {
    logic  load_in;
    logic  clear_res;
    logic  start_push;
    logic  rd_pop;
    logic  load_root;
    logic  rd_up;
    logic  rd_dn;
    wmux_t wmux;
    logic  set_full;
    logic  set_empty;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic empty;
    logic full;
    logic pos_root;
    logic up_stop;
    logic dn_stop;
  } stat_t;

endpackage

// ===== hw/rtl/timestamp_min_heap_queue_unit.sv =====
// Timestamp min-heap event queue.
// in_ channel: one word per command; op selects push (0) or pop (1).
// out_ channel: exactly one result word per command, with status, the
// popped event (zero for pushes and errors) and the fill level afterwards.
// The heap lives in one two-read, one-write RAM holding {time, tag}; the
// entry being sifted stays in a register and is written once at its slot.
// Errors answer from the check state; a push climbs and a pop descends
// the heap, and a pop that empties the queue skips the sift walk. Each
// level of the walk is a read, then a compare and move.
// One command is in flight at a time; in_ready is high only when idle and
// the output register is free or drained this cycle, so the next word can
// be accepted in the same cycle that out_valid rises, at the earliest.
// A stalled receiver holds out_valid and the result word, and blocks in_.
// Reset empties the queue (count to zero); store contents are not cleared.
// Pop on empty returns status 1; push when full returns status 2.
module timestamp_min_heap_queue_unit #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tmhq_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tmhq_pkg::out_word_t  out_data
);
  import tmhq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tmhq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  tmhq_datapath #(.DEPTH(HEAP_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd),
    .stat(stat), .res(out_data)
  );
endmodule

// ===== hw/rtl/tmhq_ram.sv =====
module tmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ===== hw/rtl/tmhq_datapath.sv =====
module tmhq_datapath #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tmhq_pkg::in_word_t in_data,
  input  tmhq_pkg::cmd_t     cmd,
  output tmhq_pkg::stat_t    stat,
  output tmhq_pkg::out_word_t res
);
  import tmhq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;
  localparam int EW = TIME_W + TAG_W;

  in_word_t          in_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  // entry being sifted; written once at its final slot
  logic [EW-1:0]     ent_r, ent_nxt;
  out_word_t         res_r, res_nxt;

  logic              we;
  logic [AW-1:0]     waddr, ra, rb;
  logic [EW-1:0]     wdata, rda, rdb;

  logic [AW-1:0]     pos_m1, parent, last_idx;
  logic [XW-1:0]     lc, rc;
  logic              lc_ok, rc_ok, dn_go_l, dn_go_r;
  logic [TIME_W-1:0] k_ent, k_a, k_b;

  tmhq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .rdata_a(rda), .raddr_b(rb), .rdata_b(rdb)
  );

  always_comb begin
    pos_m1   = pos_r - AW'(1);
    parent   = pos_m1 >> 1;
    last_idx = AW'(count_r - CW'(1));
    lc       = {1'b0, pos_r, 1'b1};
    rc       = lc + XW'(1);
    lc_ok    = lc < XW'(count_r);
    rc_ok    = rc < XW'(count_r);
    k_ent    = ent_r[EW-1 -: TIME_W];
    k_a      = rda[EW-1 -: TIME_W];
    k_b      = rdb[EW-1 -: TIME_W];
    dn_go_l  = lc_ok && (k_a < k_ent);
    dn_go_r  = rc_ok && (k_b < (dn_go_l ? k_a : k_ent));
    stat.op       = in_r.op;
    stat.empty    = count_r == '0;
    stat.full     = count_r == CW'(DEPTH);
    stat.pos_root = pos_r == '0;
    stat.up_stop  = k_a <= k_ent;
    stat.dn_stop  = !dn_go_l && !dn_go_r;
  end

  // read address selection
  always_comb begin
    ra = pos_r;
    rb = pos_r;
    if (cmd.rd_pop) begin
      ra = '0;
      rb = last_idx;
    end else if (cmd.rd_up) begin
      ra = parent;
    end else if (cmd.rd_dn) begin
      ra = lc[AW-1:0];
      rb = rc[AW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = ent_r;
    case (cmd.wmux)
      MUX_ENT: begin
        we    = 1'b1;
        wdata = ent_r;
      end
      MUX_UP: begin
        we    = 1'b1;
        wdata = rda;
      end
      MUX_DN: begin
        we    = 1'b1;
        wdata = dn_go_r ? rdb : rda;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    ent_nxt   = ent_r;
    res_nxt   = res_r;
    if (cmd.clear_res) res_nxt = '0;
    if (cmd.start_push) begin
      ent_nxt   = {in_r.due_time, in_r.slot_hint, in_r.owner_id,
                   in_r.word_count, in_r.payload_ref};
      pos_nxt   = count_r[AW-1:0];
      count_nxt = count_r + CW'(1);
    end
    if (cmd.rd_pop) count_nxt = count_r - CW'(1);
    if (cmd.load_root) begin
      ent_nxt             = rdb;
      pos_nxt             = '0;
      res_nxt.out_time    = rda[EW-1 -: TIME_W];
      res_nxt.out_slot    = rda[44:35];
      res_nxt.out_owner   = rda[34:19];
      res_nxt.out_words   = rda[18:16];
      res_nxt.out_payload = rda[15:0];
    end
    if (cmd.wmux == MUX_UP) pos_nxt = parent;
    if (cmd.wmux == MUX_DN) pos_nxt = dn_go_r ? rc[AW-1:0] : lc[AW-1:0];
    if (cmd.set_full)  res_nxt.status = ST_FULL;
    if (cmd.set_empty) res_nxt.status = ST_EMPTY;
    res_nxt.fill_level = FILL_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      res_r   <= '0;
    end else begin
      count_r <= count_nxt;
      res_r   <= res_nxt;
    end
    if (cmd.load_in) in_r <= in_data;
    pos_r <= pos_nxt;
    ent_r <= ent_nxt;
  end

  assign res = res_r;
endmodule

// ===== hw/rtl/tmhq_ctrl.sv =====
module tmhq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tmhq_pkg::stat_t stat,
  output tmhq_pkg::cmd_t  cmd
);
  import tmhq_pkg::*;
  `include "timestamp_min_heap_queue_unit_defines.svh"

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.wmux  = MUX_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = !ov_r || out_ready;
        if (in_valid && in_ready) begin
          cmd.load_in   = 1'b1;
          cmd.clear_res = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.op == OP_PUSH) begin
          if (stat.full) begin
            cmd.set_full = 1'b1;
            ov_nxt       = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.start_push = 1'b1;
            state_nxt      = S_UP_RD;
          end
        end else if (stat.empty) begin
          cmd.set_empty = 1'b1;
          ov_nxt        = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rd_pop = 1'b1;
          state_nxt  = S_POP_LD;
        end
      end
      S_POP_LD: begin
        cmd.load_root = 1'b1;
        if (stat.empty) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (stat.pos_root) begin
          cmd.wmux  = MUX_ENT;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_up = 1'b1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_stop) begin
          cmd.wmux  = MUX_ENT;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.wmux  = MUX_UP;
          state_nxt = S_UP_RD;
        end
      end
      S_DN_RD: begin
        cmd.rd_dn = 1'b1;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat.dn_stop) begin
          cmd.wmux  = MUX_ENT;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.wmux  = MUX_DN;
          state_nxt = S_DN_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;

  `TMHQ_ASSERT_IMPL(a_no_accept_busy, state_r != S_IDLE, !in_ready)
  `TMHQ_ASSERT_IMPL(a_no_out_busy, state_r != S_IDLE, !out_valid)
  `TMHQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `TMHQ_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == S_CHECK)
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tmhq_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;

  class heap_scoreboard;
    logic [31:0] keys[DEPTH];
    logic [44:0] tags[DEPTH];
    int unsigned count;
    out_word_t pending[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void swap_entries(int unsigned a, int unsigned b);
      logic [31:0] k;
      logic [44:0] t;
      k = keys[a];
      t = tags[a];
      keys[a] = keys[b];
      tags[a] = tags[b];
      keys[b] = k;
      tags[b] = t;
    endfunction

    function void note_input(in_word_t w);
      out_word_t r;
      int unsigned pos, up, lc, rc, best;
      logic [44:0] t;
      r = '0;
      if (w.op == OP_PUSH) begin
        if (count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          keys[count] = w.due_time;
          tags[count] = {w.slot_hint, w.owner_id, w.word_count, w.payload_ref};
          pos = count;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (keys[up] <= keys[pos]) break;
            swap_entries(up, pos);
            pos = up;
          end
          count++;
        end
      end else begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          t = tags[0];
          r.status = ST_OK;
          r.out_time = keys[0];
          {r.out_slot, r.out_owner, r.out_words, r.out_payload} = t;
          count--;
          if (count > 0) begin
            keys[0] = keys[count];
            tags[0] = tags[count];
            pos = 0;
            forever begin
              lc = 2 * pos + 1;
              rc = 2 * pos + 2;
              best = pos;
              if (lc < count && keys[lc] < keys[best]) best = lc;
              if (rc < count && keys[rc] < keys[best]) best = rc;
              if (best == pos) break;
              swap_entries(pos, best);
              pos = best;
            end
          end
        end
      end
      r.fill_level = count[6:0];
      pending.push_back(r);
    endfunction

    function void check_result(out_word_t a);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.out_time !== e.out_time) begin
        $error("out_time exp %0h got %0h", e.out_time, a.out_time); errors++;
      end
      if (a.out_slot !== e.out_slot) begin
        $error("out_slot exp %0h got %0h", e.out_slot, a.out_slot); errors++;
      end
      if (a.out_owner !== e.out_owner) begin
        $error("out_owner exp %0h got %0h", e.out_owner, a.out_owner); errors++;
      end
      if (a.out_words !== e.out_words) begin
        $error("out_words exp %0h got %0h", e.out_words, a.out_words); errors++;
      end
      if (a.out_payload !== e.out_payload) begin
        $error("out_payload exp %0h got %0h", e.out_payload, a.out_payload); errors++;
      end
      if (a.fill_level !== e.fill_level) begin
        $error("fill_level exp %0d got %0d", e.fill_level, a.fill_level); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_word_t in_data;
  out_word_t out_data;
  heap_scoreboard sb;
  int cycles;
  bit rx_hold;
  bit tx_done;

  timestamp_min_heap_queue_unit #(.HEAP_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // leaves in_valid high; the caller drops it when a gap follows
  task automatic send_word(in_word_t w);
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_ready === 1'b1));
    sb.note_input(w);
    @(negedge clk);
  endtask

  task automatic send_op(logic op, logic [31:0] t, bit use_gaps);
    in_word_t w;
    int g;
    w.op = op;
    w.due_time = t;
    w.slot_hint = 10'($urandom);
    w.owner_id = 16'($urandom);
    w.word_count = 3'($urandom);
    w.payload_ref = 16'($urandom);
    send_word(w);
    if (use_gaps) begin
      g = gap_len();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_time(int mode);
    case (mode)
      0: return $urandom_range(0, 7);
      1: return $urandom;
      default: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      cycles <= cycles + 1;
      if (out_valid === 1'b1 && out_ready === 1'b1) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int g;
    @(negedge clk);
    while (!tx_done || sb.pending.size() != 0) begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        rx_hold = 0;
      end else begin
        g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
    out_ready <= 1'b1;
  end

  initial begin
    int mode, bias;
    sb = new();
    cycles = 0;
    rx_hold = 0;
    tx_done = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty pop, extremes, ties, and popping past empty
    send_op(OP_POP, 32'd0, 1'b0);
    send_word('{op: OP_PUSH, due_time: 32'hFFFF_FFFF, slot_hint: 10'h3FF,
                owner_id: 16'hFFFF, word_count: 3'h7, payload_ref: 16'hFFFF});
    send_word('{op: OP_PUSH, due_time: 32'h0, slot_hint: 10'h0,
                owner_id: 16'h0, word_count: 3'h0, payload_ref: 16'h0});
    send_op(OP_PUSH, 32'd5, 1'b0);
    send_op(OP_PUSH, 32'd5, 1'b0);
    send_op(OP_PUSH, 32'd5, 1'b0);
    repeat (6) send_op(OP_POP, 32'd0, 1'b0);
    wait_drained();

    // fill with long receiver hold-off so the block stalls its input
    rx_hold = 1;
    repeat (DEPTH + 3) send_op(OP_PUSH, rand_time($urandom_range(0, 2)), 1'b0);
    repeat (DEPTH + 2) send_op(OP_POP, 32'd0, 1'b0);
    wait_drained();

    // random phases with varying push/pop bias
    for (int i = 0; i < 1500; i++) begin
      if (i % 150 == 0) begin
        bias = $urandom_range(20, 80);
        mode = $urandom_range(0, 2);
      end
      if (i % 300 == 299) wait_drained();
      send_op(($urandom_range(0, 99) < bias) ? OP_PUSH : OP_POP,
              rand_time(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : mode),
              1'b1);
    end
    tx_done = 1;
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
